FILE: sv/ws_enc_pkg.sv
// shared types, constants and arithmetic helpers for the ws2812 pixel encoder
package ws_enc_pkg;

    localparam int DEFAULT_LED_COUNT = 8;
    localparam int INDEX_W           = 3;
    localparam int CHAN_W            = 8;
    localparam int TICK_W            = 8;
    localparam int CFG_INDEX_W       = 3;
    localparam int SYMBOLS_PER_PIXEL = 24;
    localparam int SYM_CNT_W         = 5;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_CAP  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW_TICKS  = 3'd4;

    localparam logic [CHAN_W-1:0] RESET_BRIGHTNESS_CAP  = 8'd110;
    localparam logic [TICK_W-1:0] RESET_ONE_HIGH_TICKS  = 8'd8;
    localparam logic [TICK_W-1:0] RESET_ONE_LOW_TICKS   = 8'd5;
    localparam logic [TICK_W-1:0] RESET_ZERO_HIGH_TICKS = 8'd4;
    localparam logic [TICK_W-1:0] RESET_ZERO_LOW_TICKS  = 8'd8;

    localparam logic [15:0] BLEND_NEW_WEIGHT = 16'd102;
    localparam logic [15:0] BLEND_OLD_WEIGHT = 16'd153;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] b;
        logic              frame_last;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] brightness_cap;
        logic [TICK_W-1:0] one_high_ticks;
        logic [TICK_W-1:0] one_low_ticks;
        logic [TICK_W-1:0] zero_high_ticks;
        logic [TICK_W-1:0] zero_low_ticks;
    } cfg_t;

    localparam logic [7:0] GAMMA_ROM [256] = '{
          0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,
          0,  0,  0,  0,  0,  0,  0,  0,  1,  1,  1,  1,  1,  1,  1,  1,
          1,  1,  1,  1,  2,  2,  2,  2,  2,  2,  2,  2,  3,  3,  3,  3,
          3,  3,  4,  4,  4,  4,  5,  5,  5,  5,  5,  6,  6,  6,  6,  7,
          7,  7,  8,  8,  8,  9,  9,  9, 10, 10, 10, 11, 11, 11, 12, 12,
         13, 13, 13, 14, 14, 15, 15, 16, 16, 17, 17, 18, 18, 19, 19, 20,
         20, 21, 21, 22, 22, 23, 24, 24, 25, 25, 26, 27, 27, 28, 29, 29,
         30, 31, 31, 32, 33, 34, 34, 35, 36, 37, 38, 38, 39, 40, 41, 42,
         42, 43, 44, 45, 46, 47, 48, 49, 50, 51, 52, 53, 54, 55, 56, 57,
         58, 59, 60, 61, 62, 63, 64, 65, 66, 68, 69, 70, 71, 72, 73, 75,
         76, 77, 78, 80, 81, 82, 84, 85, 86, 88, 89, 90, 92, 93, 94, 96,
         97, 99,100,102,103,105,106,108,109,111,112,114,115,117,119,120,
        122,124,125,127,129,130,132,134,136,137,139,141,143,145,146,148,
        150,152,154,156,158,160,162,164,166,168,170,172,174,176,178,180,
        182,184,186,188,191,193,195,197,199,202,204,206,209,211,213,215,
        218,220,223,225,227,230,232,235,237,240,242,245,247,250,252,255
    };

    // exact floor(x / 255) for x up to 65279
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] fresh, input logic [7:0] old);
        logic [15:0] sum;
        sum = 16'(fresh) * BLEND_NEW_WEIGHT + 16'(old) * BLEND_OLD_WEIGHT;
        return div255(sum);
    endfunction

endpackage

FILE: sv/ws_enc_front.sv
// front end: accepts pixels, applies smear with the frame store, scales and gammas
module ws_enc_front #(
    parameter int LED_COUNT = ws_enc_pkg::DEFAULT_LED_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [ws_enc_pkg::INDEX_W-1:0]      led_index,
    input  logic [ws_enc_pkg::CHAN_W-1:0]       red,
    input  logic [ws_enc_pkg::CHAN_W-1:0]       green,
    input  logic [ws_enc_pkg::CHAN_W-1:0]       blue,
    input  logic                                smear,
    input  logic [ws_enc_pkg::CHAN_W-1:0]       brightness_cap,
    output logic                                q_push,
    output ws_enc_pkg::pix_t                    q_data,
    input  logic                                q_full
);
    import ws_enc_pkg::*;

    localparam int STORE_DEPTH = (LED_COUNT < 8) ? LED_COUNT : 8;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LAST_POS    = LED_COUNT - 1;

    rgb_t               prev_reg [STORE_DEPTH];
    logic               s1_valid_reg;
    rgb_t               s1_chan_reg;
    logic               s1_last_reg;
    logic               s2_valid_reg;
    rgb_t               s2_chan_reg;
    logic               s2_last_reg;

    logic               accept;
    logic               in_ring;
    logic               is_last;
    logic [IDX_W-1:0]   idx;
    rgb_t               prev_rd;
    rgb_t               chan_new;
    logic               s2_take;
    logic               s1_move;

    assign in_ring = 32'(led_index) < LED_COUNT;
    assign is_last = (LAST_POS <= 7) && (32'(led_index) == LAST_POS);
    assign idx     = led_index[IDX_W-1:0];
    assign prev_rd = in_ring ? prev_reg[idx] : '0;

    always_comb
    begin
        chan_new.r = smear ? blend(red, prev_rd.r) : red;
        chan_new.g = smear ? blend(green, prev_rd.g) : green;
        chan_new.b = smear ? blend(blue, prev_rd.b) : blue;
    end

    assign q_push  = s2_valid_reg && !q_full;
    assign s2_take = !s2_valid_reg || q_push;
    assign s1_move = s1_valid_reg && s2_take;
    assign full    = s1_valid_reg && !s2_take;
    assign accept  = push && !full;

    always_comb
    begin
        q_data.g          = GAMMA_ROM[s2_chan_reg.g];
        q_data.r          = GAMMA_ROM[s2_chan_reg.r];
        q_data.b          = GAMMA_ROM[s2_chan_reg.b];
        q_data.frame_last = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else if (accept && in_ring)
        begin
            prev_reg[idx] <= chan_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_chan_reg <= chan_new;
            s1_last_reg <= in_ring && is_last;
        end
        if (s1_move)
        begin
            s2_chan_reg.r <= div255(16'(s1_chan_reg.r) * 16'(brightness_cap));
            s2_chan_reg.g <= div255(16'(s1_chan_reg.g) * 16'(brightness_cap));
            s2_chan_reg.b <= div255(16'(s1_chan_reg.b) * 16'(brightness_cap));
            s2_last_reg   <= s1_last_reg;
        end
    end

endmodule

FILE: sv/ws_enc_queue.sv
// short pixel queue between front and back
module ws_enc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ws_enc_pkg::pix_t    wr_data,
    output logic                full,
    input  logic                rd_en,
    output ws_enc_pkg::pix_t    rd_data,
    output logic                empty
);
    import ws_enc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pix_t               mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: sv/ws_enc_back.sv
// back end: serializes each pixel into 24 bit symbols, msb first
module ws_enc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  ws_enc_pkg::pix_t                q_data,
    output logic                            q_pop,
    input  ws_enc_pkg::cfg_t                cfg,
    output logic                            empty,
    input  logic                            pop,
    output logic                            bit_value,
    output logic [ws_enc_pkg::TICK_W-1:0]   high_ticks,
    output logic [ws_enc_pkg::TICK_W-1:0]   low_ticks,
    output logic                            pixel_done,
    output logic                            frame_done
);
    import ws_enc_pkg::*;

    logic                       cur_valid_reg;
    logic [SYMBOLS_PER_PIXEL-1:0] shift_reg;
    logic [SYM_CNT_W-1:0]       cnt_reg;
    logic                       last_reg;
    logic                       taken;
    logic                       finishing;

    assign empty      = !cur_valid_reg;
    assign taken      = pop && cur_valid_reg;
    assign pixel_done = cnt_reg == SYM_CNT_W'(SYMBOLS_PER_PIXEL - 1);
    assign finishing  = taken && pixel_done;
    assign q_pop      = !q_empty && (!cur_valid_reg || finishing);

    assign bit_value  = shift_reg[SYMBOLS_PER_PIXEL-1];
    assign high_ticks = bit_value ? cfg.one_high_ticks : cfg.zero_high_ticks;
    assign low_ticks  = bit_value ? cfg.one_low_ticks : cfg.zero_low_ticks;
    assign frame_done = pixel_done && last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else if (finishing)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (taken)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            shift_reg <= {q_data.g, q_data.r, q_data.b};
            last_reg  <= q_data.frame_last;
        end
        else if (taken)
        begin
            shift_reg <= {shift_reg[SYMBOLS_PER_PIXEL-2:0], 1'b0};
        end
    end

endmodule

FILE: sv/led_pixel_smear_gamma_ws2812_encoder.sv
// top level of the ws2812 pixel encoder with smear, brightness cap and gamma
//
//  channel   handshake              word
//  pixel in  push / full            led_index, red, green, blue, smear
//  symbol    pop / empty            bit_value, high_ticks, low_ticks, pixel_done, frame_done
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each pixel gives 24 symbols, one per cycle while pop is held and a symbol is
// ready; the serializer sets that rate
// an accepted pixel passes the two front stage registers, the queue and the serializer shift register
// the frame store clears at reset, no sweep; config is always ready
// a two-pixel queue lets the front take pixels while symbols stall
module led_pixel_smear_gamma_ws2812_encoder #(
    parameter int LED_COUNT = ws_enc_pkg::DEFAULT_LED_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [ws_enc_pkg::INDEX_W-1:0]      led_index,
    input  logic [ws_enc_pkg::CHAN_W-1:0]       red,
    input  logic [ws_enc_pkg::CHAN_W-1:0]       green,
    input  logic [ws_enc_pkg::CHAN_W-1:0]       blue,
    input  logic                                smear,
    output logic                                empty,
    input  logic                                pop,
    output logic                                bit_value,
    output logic [ws_enc_pkg::TICK_W-1:0]       high_ticks,
    output logic [ws_enc_pkg::TICK_W-1:0]       low_ticks,
    output logic                                pixel_done,
    output logic                                frame_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ws_enc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ws_enc_pkg::CHAN_W-1:0]       cfg_data
);
    import ws_enc_pkg::*;

    cfg_t   cfg_reg;
    logic   fq_push;
    pix_t   fq_data;
    logic   fq_full;
    logic   bq_pop;
    pix_t   bq_data;
    logic   bq_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness_cap  <= RESET_BRIGHTNESS_CAP;
            cfg_reg.one_high_ticks  <= RESET_ONE_HIGH_TICKS;
            cfg_reg.one_low_ticks   <= RESET_ONE_LOW_TICKS;
            cfg_reg.zero_high_ticks <= RESET_ZERO_HIGH_TICKS;
            cfg_reg.zero_low_ticks  <= RESET_ZERO_LOW_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS_CAP:  cfg_reg.brightness_cap  <= cfg_data;
                REG_ONE_HIGH_TICKS:  cfg_reg.one_high_ticks  <= cfg_data;
                REG_ONE_LOW_TICKS:   cfg_reg.one_low_ticks   <= cfg_data;
                REG_ZERO_HIGH_TICKS: cfg_reg.zero_high_ticks <= cfg_data;
                REG_ZERO_LOW_TICKS:  cfg_reg.zero_low_ticks  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ws_enc_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .led_index      (led_index),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .smear          (smear),
        .brightness_cap (cfg_reg.brightness_cap),
        .q_push         (fq_push),
        .q_data         (fq_data),
        .q_full         (fq_full)
    );

    ws_enc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_data),
        .full    (fq_full),
        .rd_en   (bq_pop),
        .rd_data (bq_data),
        .empty   (bq_empty)
    );

    ws_enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (bq_empty),
        .q_data     (bq_data),
        .q_pop      (bq_pop),
        .cfg        (cfg_reg),
        .empty      (empty),
        .pop        (pop),
        .bit_value  (bit_value),
        .high_ticks (high_ticks),
        .low_ticks  (low_ticks),
        .pixel_done (pixel_done),
        .frame_done (frame_done)
    );

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the ws2812 pixel encoder: smear, brightness cap, gamma and bit symbols
`timescale 1ns / 100ps

module tb_top;

    import ws_enc_pkg::*;

    localparam int    RING_SIZE      = DEFAULT_LED_COUNT;
    localparam int    FRESH_WEIGHT   = 102;
    localparam int    HISTORY_WEIGHT = 153;
    localparam int    FULL_SCALE     = 255;
    localparam int    MAX_GAP        = 11;
    localparam int    HOLD_CYCLES    = 400;
    localparam int    DRAIN_SLACK    = 16;
    localparam int    PHASE_ITEMS    = 17;
    localparam int    PHASE_COUNT    = 5;
    localparam int    MAX_REPORTS    = 10;
    localparam int    REG_COUNT      = 2 ** CFG_INDEX_W;
    localparam real   TIMEOUT_NS     = 5_000_000.0;

    localparam logic [7:0] GAMMA_LUT [256] = '{
          0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,
          0,  0,  0,  0,  0,  0,  0,  0,  1,  1,  1,  1,  1,  1,  1,  1,
          1,  1,  1,  1,  2,  2,  2,  2,  2,  2,  2,  2,  3,  3,  3,  3,
          3,  3,  4,  4,  4,  4,  5,  5,  5,  5,  5,  6,  6,  6,  6,  7,
          7,  7,  8,  8,  8,  9,  9,  9, 10, 10, 10, 11, 11, 11, 12, 12,
         13, 13, 13, 14, 14, 15, 15, 16, 16, 17, 17, 18, 18, 19, 19, 20,
         20, 21, 21, 22, 22, 23, 24, 24, 25, 25, 26, 27, 27, 28, 29, 29,
         30, 31, 31, 32, 33, 34, 34, 35, 36, 37, 38, 38, 39, 40, 41, 42,
         42, 43, 44, 45, 46, 47, 48, 49, 50, 51, 52, 53, 54, 55, 56, 57,
         58, 59, 60, 61, 62, 63, 64, 65, 66, 68, 69, 70, 71, 72, 73, 75,
         76, 77, 78, 80, 81, 82, 84, 85, 86, 88, 89, 90, 92, 93, 94, 96,
         97, 99,100,102,103,105,106,108,109,111,112,114,115,117,119,120,
        122,124,125,127,129,130,132,134,136,137,139,141,143,145,146,148,
        150,152,154,156,158,160,162,164,166,168,170,172,174,176,178,180,
        182,184,186,188,191,193,195,197,199,202,204,206,209,211,213,215,
        218,220,223,225,227,230,232,235,237,240,242,245,247,250,252,255
    };

    typedef struct packed {
        logic              bit_value;
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] low_ticks;
        logic              pixel_done;
        logic              frame_done;
    } symbol_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [INDEX_W-1:0]     led_index;
    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      blue;
    logic                   smear;
    logic                   empty;
    logic                   pop;
    logic                   bit_value;
    logic [TICK_W-1:0]      high_ticks;
    logic [TICK_W-1:0]      low_ticks;
    logic                   pixel_done;
    logic                   frame_done;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CHAN_W-1:0]      cfg_data;

    // predictor copy of the configuration and the frame store
    logic [CHAN_W-1:0]      cap_level;
    logic [TICK_W-1:0]      one_high_len;
    logic [TICK_W-1:0]      one_low_len;
    logic [TICK_W-1:0]      zero_high_len;
    logic [TICK_W-1:0]      zero_low_len;
    logic [CHAN_W-1:0]      last_frame [RING_SIZE][3];

    symbol_t                pending_symbols [$];
    int                     failures;
    int                     reports;
    bit                     tx_fast;
    bit                     rx_fast;
    bit                     rx_hold;
    bit                     hold_request;

    led_pixel_smear_gamma_ws2812_encoder #(
        .LED_COUNT (RING_SIZE)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .led_index  (led_index),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .smear      (smear),
        .empty      (empty),
        .pop        (pop),
        .bit_value  (bit_value),
        .high_ticks (high_ticks),
        .low_ticks  (low_ticks),
        .pixel_done (pixel_done),
        .frame_done (frame_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [CHAN_W-1:0] smear_channel(input logic [CHAN_W-1:0] fresh,
                                                        input logic [CHAN_W-1:0] history);
        int sum;
        sum = int'(fresh) * FRESH_WEIGHT + int'(history) * HISTORY_WEIGHT;
        return CHAN_W'(sum / FULL_SCALE);
    endfunction

    function automatic logic [CHAN_W-1:0] shade(input logic [CHAN_W-1:0] level);
        int scaled;
        scaled = int'(level) * int'(cap_level) / FULL_SCALE;
        return GAMMA_LUT[scaled];
    endfunction

    function automatic logic [CHAN_W-1:0] rand_level();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic predict_pixel(input logic [INDEX_W-1:0] pos, input logic [CHAN_W-1:0] r,
                                 input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                                 input logic sm);
        logic [CHAN_W-1:0] chan [3];
        logic [CHAN_W-1:0] history;
        logic [23:0]       grb;
        logic              in_ring;
        symbol_t           sym;
        chan[0] = r;
        chan[1] = g;
        chan[2] = b;
        in_ring = int'(pos) < RING_SIZE;
        for (int c = 0; c < 3; c++)
        begin
            history = in_ring ? last_frame[pos][c] : '0;
            if (sm)
                chan[c] = smear_channel(chan[c], history);
            if (in_ring)
                last_frame[pos][c] = chan[c];
        end
        grb = {shade(chan[1]), shade(chan[0]), shade(chan[2])};
        for (int k = 0; k < SYMBOLS_PER_PIXEL; k++)
        begin
            sym.bit_value  = grb[SYMBOLS_PER_PIXEL-1-k];
            sym.high_ticks = sym.bit_value ? one_high_len : zero_high_len;
            sym.low_ticks  = sym.bit_value ? one_low_len : zero_low_len;
            sym.pixel_done = (k == SYMBOLS_PER_PIXEL-1);
            sym.frame_done = sym.pixel_done && in_ring && (int'(pos) == RING_SIZE-1);
            pending_symbols.push_back(sym);
        end
    endtask

    task automatic send_pixel(input logic [INDEX_W-1:0] pos, input logic [CHAN_W-1:0] r,
                              input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                              input logic sm);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        led_index <= pos;
        red       <= r;
        green     <= g;
        blue      <= b;
        smear     <= sm;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_pixel(pos, r, g, b, sm);
    endtask

    task automatic send_random_pixel(input logic [INDEX_W-1:0] pos);
        send_pixel(pos, rand_level(), rand_level(), rand_level(), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CHAN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BRIGHTNESS_CAP:  cap_level     = data;
            REG_ONE_HIGH_TICKS:  one_high_len  = data;
            REG_ONE_LOW_TICKS:   one_low_len   = data;
            REG_ZERO_HIGH_TICKS: zero_high_len = data;
            REG_ZERO_LOW_TICKS:  zero_low_len  = data;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [CHAN_W-1:0] cap, input logic [TICK_W-1:0] oh,
                                  input logic [TICK_W-1:0] ol, input logic [TICK_W-1:0] zh,
                                  input logic [TICK_W-1:0] zl);
        write_reg(REG_BRIGHTNESS_CAP, cap);
        write_reg(REG_ONE_HIGH_TICKS, oh);
        write_reg(REG_ONE_LOW_TICKS, ol);
        write_reg(REG_ZERO_HIGH_TICKS, zh);
        write_reg(REG_ZERO_LOW_TICKS, zl);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_pixel(3'd0, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(3'd1, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(3'd2, 8'd255, 8'd0, 8'd128, 1'b1);
        send_pixel(3'(RING_SIZE-1), 8'd170, 8'd85, 8'd1, 1'b0);
        wait_idle();
    endtask

    task automatic test_brightness_cap();
        write_reg(REG_BRIGHTNESS_CAP, 8'd255);
        send_pixel(3'd3, 8'd255, 8'd128, 8'd1, 1'b0);
        send_pixel(3'd4, 8'hAA, 8'h55, 8'hFF, 1'b0);
        wait_idle();
        write_reg(REG_BRIGHTNESS_CAP, 8'd0);
        send_pixel(3'd5, 8'd255, 8'd255, 8'd255, 1'b0);
        wait_idle();
        write_reg(REG_BRIGHTNESS_CAP, 8'd1);
        send_pixel(3'd6, 8'd255, 8'd255, 8'd255, 1'b0);
        wait_idle();
    endtask

    task automatic test_smear_history();
        write_reg(REG_BRIGHTNESS_CAP, 8'd255);
        send_pixel(3'd0, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(3'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(3'd0, 8'd255, 8'd0, 8'd255, 1'b1);
        send_pixel(3'd0, 8'd10, 8'd20, 8'd30, 1'b1);
        send_pixel(3'(RING_SIZE-1), 8'd255, 8'd255, 8'd255, 1'b1);
        wait_idle();
    endtask

    task automatic test_tick_lengths();
        write_all_regs(8'd255, 8'd255, 8'd1, 8'd0, 8'd255);
        send_pixel(3'd1, 8'hFF, 8'hC0, 8'hF0, 1'b0);
        wait_idle();
        write_all_regs(8'd255, 8'd0, 8'd0, 8'd1, 8'd0);
        send_pixel(3'd2, 8'hF0, 8'hFF, 8'hC3, 1'b0);
        wait_idle();
    endtask

    task automatic test_unknown_regs();
        write_all_regs(8'd200, 8'd9, 8'd6, 8'd3, 8'd7);
        for (int i = int'(REG_ZERO_LOW_TICKS) + 1; i < REG_COUNT; i++)
            write_reg(CFG_INDEX_W'(i), CHAN_W'($urandom_range(0, 255)));
        send_pixel(3'd3, 8'd200, 8'd100, 8'd50, 1'b1);
        wait_idle();
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        tx_fast      = 1'b1;
        @(posedge clk);
        for (int p = 0; p < RING_SIZE; p++)
            send_random_pixel(INDEX_W'(p));
        tx_fast = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int sent;
        int run;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       write_all_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                1:       write_all_regs(8'd128, 8'd1, 8'd1, 8'd1, 8'd1);
                default:
                begin
                    repeat ($urandom_range(0, 4))
                        write_reg(CFG_INDEX_W'($urandom_range(0, REG_COUNT-1)),
                                  CHAN_W'($urandom_range(0, 255)));
                    write_all_regs(CHAN_W'($urandom_range(0, 255)),
                                   TICK_W'($urandom_range(0, 255)),
                                   TICK_W'($urandom_range(0, 255)),
                                   TICK_W'($urandom_range(0, 255)),
                                   TICK_W'($urandom_range(0, 255)));
                end
            endcase
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            sent    = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_random_pixel(INDEX_W'($urandom_range(0, 2**INDEX_W-1)));
                    sent++;
                end
                else
                begin
                    // up to one whole ring in order so smear sees the previous frame
                    run = (PHASE_ITEMS - sent < RING_SIZE) ? PHASE_ITEMS - sent : RING_SIZE;
                    for (int p = 0; p < run; p++)
                        send_random_pixel(INDEX_W'(p));
                    sent += run;
                end
            end
            wait_idle();
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    // long receiver hold-off so the input side backs up
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            wait (hold_request);
            @(posedge clk);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold      = 1'b0;
            hold_request = 1'b0;
        end
    end

    initial
    begin
        symbol_t got;
        symbol_t want;
        int      gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0 || rx_hold)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                while (rx_hold)
                    @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            got = '{bit_value, high_ticks, low_ticks, pixel_done, frame_done};
            if (pending_symbols.size() == 0)
            begin
                failures++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("unexpected word: bit %0d high %0d low %0d pixel %0d frame %0d",
                             got.bit_value, got.high_ticks, got.low_ticks,
                             got.pixel_done, got.frame_done);
                end
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (got !== want)
                begin
                    failures++;
                    if (reports < MAX_REPORTS)
                    begin
                        reports++;
                        $display("exp/act b %0d/%0d h %0d/%0d l %0d/%0d p %0d/%0d f %0d/%0d",
                                 want.bit_value, got.bit_value, want.high_ticks, got.high_ticks,
                                 want.low_ticks, got.low_ticks, want.pixel_done, got.pixel_done,
                                 want.frame_done, got.frame_done);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        led_index    = '0;
        red          = '0;
        green        = '0;
        blue         = '0;
        smear        = 1'b0;
        pop          = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        failures     = 0;
        reports      = 0;
        tx_fast      = 1'b0;
        rx_fast      = 1'b0;
        hold_request = 1'b0;
        cap_level     = RESET_BRIGHTNESS_CAP;
        one_high_len  = RESET_ONE_HIGH_TICKS;
        one_low_len   = RESET_ONE_LOW_TICKS;
        zero_high_len = RESET_ZERO_HIGH_TICKS;
        zero_low_len  = RESET_ZERO_LOW_TICKS;
        for (int p = 0; p < RING_SIZE; p++)
            for (int c = 0; c < 3; c++)
                last_frame[p][c] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_values();
        test_brightness_cap();
        test_smear_history();
        test_tick_lengths();
        test_unknown_regs();
        test_output_stall();
        test_random_frames();

        wait_idle();
        if (failures == 0 && pending_symbols.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
